/* rtl/http_request_field_tokenizer_defines.svh */
// ----------------------------------------------------------------------------
// HTTP request field tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_FIELD_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_FIELD_TOKENIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HRFT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HRFT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrft_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP request field tokenizer package
// Payload types, result codes, register map and defaults.
// ----------------------------------------------------------------------------
package hrft_pkg;

    localparam int HRFT_PATH_MAX_BYTES   = 2048;
    localparam int HRFT_HEADER_INDEX_MAX = 255;

    // Result queue depth; an input transfer needs room for two results.
    localparam int HRFT_QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_REQ_END  = 2'd2;

    localparam logic [2:0] FIELD_METHOD   = 3'd0;
    localparam logic [2:0] FIELD_PATH     = 3'd1;
    localparam logic [2:0] FIELD_PROTOCOL = 3'd2;
    localparam logic [2:0] FIELD_KEY      = 3'd3;
    localparam logic [2:0] FIELD_VALUE    = 3'd4;

    typedef enum logic [2:0] {
        REG_METHOD_LIMIT   = 3'd0,
        REG_PATH_LIMIT     = 3'd1,
        REG_PROTOCOL_LIMIT = 3'd2,
        REG_KEY_LIMIT      = 3'd3,
        REG_VALUE_LIMIT    = 3'd4
    } hrft_reg_t;

    localparam logic [2:0]  METHOD_LIMIT_RST   = 3'd7;
    localparam logic [10:0] PATH_LIMIT_RST     = 11'd2047;
    localparam logic [3:0]  PROTOCOL_LIMIT_RST = 4'd15;
    localparam logic [7:0]  KEY_LIMIT_RST      = 8'd255;
    localparam logic [8:0]  VALUE_LIMIT_RST    = 9'd511;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } hrft_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  field;
        logic [7:0]  header_number;
        logic [10:0] offset;
        logic        truncated;
        logic [7:0]  out_byte;
        logic        last;
    } hrft_result_t;

    typedef struct packed {
        logic [2:0]  method_limit;
        logic [10:0] path_limit;
        logic [3:0]  protocol_limit;
        logic [7:0]  key_limit;
        logic [8:0]  value_limit;
    } hrft_limits_t;

    // Up to two results produced by one accepted byte, in order.
    typedef struct packed {
        logic         v0;
        logic         v1;
        hrft_result_t r0;
        hrft_result_t r1;
    } hrft_emit_t;

endpackage

/* rtl/hrft_parser.sv */
// ----------------------------------------------------------------------------
// HTTP request field tokenizer parse engine
// Per-byte parse state and the combinational classification of each byte.
// ----------------------------------------------------------------------------
module hrft_parser #(
    parameter int PATH_MAX_BYTES   = hrft_pkg::HRFT_PATH_MAX_BYTES,
    parameter int HEADER_INDEX_MAX = hrft_pkg::HRFT_HEADER_INDEX_MAX
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  hrft_pkg::hrft_in_t    in_item,
    input  hrft_pkg::hrft_limits_t limits,
    output hrft_pkg::hrft_emit_t  ev
);
    import hrft_pkg::*;
    `include "http_request_field_tokenizer_defines.svh"

    localparam int HC_W = $clog2(HEADER_INDEX_MAX + 1);
    localparam int PATH_CAP_I = (PATH_MAX_BYTES - 1 < 2047) ? PATH_MAX_BYTES - 1 : 2047;
    localparam logic [10:0] PATH_CAP = 11'(PATH_CAP_I);
    localparam logic [HC_W-1:0] HC_MAX = HC_W'(HEADER_INDEX_MAX);

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;

    typedef enum logic [3:0] {
        PH_METHOD     = 4'd0,
        PH_SKIP_PATH  = 4'd1,
        PH_PATH       = 4'd2,
        PH_SKIP_PROTO = 4'd3,
        PH_PROTO      = 4'd4,
        PH_GAP        = 4'd5,
        PH_KEY        = 4'd6,
        PH_VALUE_SKIP = 4'd7,
        PH_VALUE      = 4'd8
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [10:0]     len_reg, len_next;
    logic [HC_W-1:0] hc_reg, hc_next;
    logic            held_reg, held_next;
    logic            drop_reg, drop_next;
    logic [1:0]      ep_reg, ep_next;

    // State as seen by this byte, after an optional restart.
    phase_t          cur_phase;
    logic [10:0]     cur_len;
    logic [HC_W-1:0] cur_hc;
    logic            cur_held;
    logic            cur_drop;
    logic [1:0]      cur_ep;

    logic [7:0]      b;
    logic            ws;
    logic            keep_a, keep_b, end_f, req_end;
    logic [2:0]      fa, fe;
    logic [7:0]      ba;
    logic [10:0]     lim_a, lim_v, len_a;
    logic            a_ok, b_ok, drop_a;
    logic [HC_W+7:0] hc_ext;
    logic [7:0]      hnum;
    hrft_result_t    byte_a, byte_b, end_res, req_res;
    logic            in_value, req_out, state_clear, pair_ok;

    function automatic logic [10:0] lim_of(input logic [2:0] f, input hrft_limits_t l);
        logic [10:0] r;
        r = 11'd0;
        case (f)
            FIELD_METHOD:   r = {8'd0, l.method_limit};
            FIELD_PATH:     r = (l.path_limit > PATH_CAP) ? PATH_CAP : l.path_limit;
            FIELD_PROTOCOL: r = {7'd0, l.protocol_limit};
            FIELD_KEY:      r = {3'd0, l.key_limit};
            FIELD_VALUE:    r = {2'd0, l.value_limit};
            default:        r = 11'd0;
        endcase
        return r;
    endfunction

    assign b  = in_item.data_byte;
    assign ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

    always_comb begin
        if (in_item.restart) begin
            cur_phase = PH_METHOD;
            cur_len   = 11'd0;
            cur_hc    = '0;
            cur_held  = 1'b0;
            cur_drop  = 1'b0;
            cur_ep    = 2'd0;
        end else begin
            cur_phase = phase_reg;
            cur_len   = len_reg;
            cur_hc    = hc_reg;
            cur_held  = held_reg;
            cur_drop  = drop_reg;
            cur_ep    = ep_reg;
        end
    end

    // Phase transitions and which actions this byte takes.
    always_comb begin
        phase_next = cur_phase;
        hc_next    = cur_hc;
        held_next  = cur_held;
        ep_next    = cur_ep;
        keep_a     = 1'b0;
        keep_b     = 1'b0;
        end_f      = 1'b0;
        req_end    = 1'b0;
        fa         = FIELD_METHOD;
        fe         = FIELD_METHOD;
        ba         = b;
        unique case (cur_phase)
            PH_SKIP_PATH: begin
                if (!ws) begin
                    phase_next = PH_PATH;
                    keep_a     = 1'b1;
                    fa         = FIELD_PATH;
                end
            end
            PH_PATH: begin
                if (ws) begin
                    end_f      = 1'b1;
                    fe         = FIELD_PATH;
                    phase_next = PH_SKIP_PROTO;
                    ep_next    = (b == CH_CR) ? 2'd1 : 2'd0;
                end else begin
                    keep_a = 1'b1;
                    fa     = FIELD_PATH;
                end
            end
            PH_SKIP_PROTO: begin
                if (!ws) begin
                    phase_next = PH_PROTO;
                    keep_a     = 1'b1;
                    fa         = FIELD_PROTOCOL;
                end
            end
            PH_PROTO: begin
                if (ws) begin
                    end_f      = 1'b1;
                    fe         = FIELD_PROTOCOL;
                    phase_next = PH_GAP;
                    ep_next    = (b == CH_CR) ? 2'd1 : 2'd0;
                end else begin
                    keep_a = 1'b1;
                    fa     = FIELD_PROTOCOL;
                end
            end
            PH_GAP: begin
                // ep counts progress through the CR LF CR LF end marker.
                if (b == CH_CR) begin
                    ep_next = (cur_ep == 2'd2) ? 2'd3 : 2'd1;
                end else if (b == CH_LF) begin
                    if (cur_ep == 2'd1) begin
                        ep_next = 2'd2;
                    end else if (cur_ep == 2'd3) begin
                        req_end    = 1'b1;
                        phase_next = PH_METHOD;
                        hc_next    = '0;
                        held_next  = 1'b0;
                        ep_next    = 2'd0;
                    end else begin
                        ep_next = 2'd0;
                    end
                end else if (ws) begin
                    ep_next = 2'd0;
                end else begin
                    ep_next    = 2'd0;
                    phase_next = PH_KEY;
                    keep_a     = 1'b1;
                    fa         = FIELD_KEY;
                end
            end
            PH_KEY: begin
                if (b == CH_COLON) begin
                    end_f      = 1'b1;
                    fe         = FIELD_KEY;
                    phase_next = PH_VALUE_SKIP;
                end else begin
                    keep_a = 1'b1;
                    fa     = FIELD_KEY;
                end
            end
            PH_VALUE_SKIP: begin
                if (b == CH_CR) begin
                    held_next  = 1'b1;
                    phase_next = PH_VALUE;
                end else if (!ws) begin
                    phase_next = PH_VALUE;
                    keep_a     = 1'b1;
                    fa         = FIELD_VALUE;
                end
            end
            PH_VALUE: begin
                if (cur_held) begin
                    held_next = 1'b0;
                    if (b == CH_LF) begin
                        end_f      = 1'b1;
                        fe         = FIELD_VALUE;
                        phase_next = PH_GAP;
                        ep_next    = 2'd2;
                        if (cur_hc < HC_MAX) begin
                            hc_next = cur_hc + HC_W'(1);
                        end
                    end else begin
                        // The held CR turns into a value byte ahead of this one.
                        keep_a = 1'b1;
                        fa     = FIELD_VALUE;
                        ba     = CH_CR;
                        if (b == CH_CR) begin
                            held_next = 1'b1;
                        end else begin
                            keep_b = 1'b1;
                        end
                    end
                end else if (b == CH_CR) begin
                    held_next = 1'b1;
                end else begin
                    keep_a = 1'b1;
                    fa     = FIELD_VALUE;
                end
            end
            default: begin
                // The method phase; unused codes behave the same way.
                phase_next = PH_METHOD;
                if (ws) begin
                    end_f      = 1'b1;
                    fe         = FIELD_METHOD;
                    phase_next = PH_SKIP_PATH;
                    ep_next    = (b == CH_CR) ? 2'd1 : 2'd0;
                end else begin
                    keep_a = 1'b1;
                    fa     = FIELD_METHOD;
                end
            end
        endcase
    end

    assign lim_a  = lim_of(fa, limits);
    assign lim_v  = lim_of(FIELD_VALUE, limits);
    assign a_ok   = keep_a && (cur_len < lim_a);
    assign len_a  = a_ok ? cur_len + 11'd1 : cur_len;
    assign drop_a = cur_drop | (keep_a & ~a_ok);
    assign b_ok   = keep_b && (len_a < lim_v);

    always_comb begin
        if (end_f || req_end) begin
            len_next  = 11'd0;
            drop_next = 1'b0;
        end else begin
            len_next  = b_ok ? len_a + 11'd1 : len_a;
            drop_next = drop_a | (keep_b & ~b_ok);
        end
    end

    assign hc_ext = {8'd0, cur_hc};
    assign hnum   = hc_ext[7:0];

    always_comb begin
        byte_a = '{kind: KIND_BYTE, field: fa, header_number: hnum, offset: cur_len,
                   truncated: 1'b0, out_byte: ba, last: 1'b0};
        byte_b = '{kind: KIND_BYTE, field: FIELD_VALUE, header_number: hnum, offset: len_a,
                   truncated: 1'b0, out_byte: b, last: 1'b1};
        end_res = '{kind: KIND_FIELD_END, field: fe, header_number: hnum, offset: cur_len,
                    truncated: cur_drop, out_byte: 8'd0, last: 1'b0};
        req_res = '{kind: KIND_REQ_END, field: FIELD_METHOD, header_number: hnum,
                    offset: 11'd0, truncated: 1'b0, out_byte: 8'd0, last: 1'b0};

        ev.v1 = accept && a_ok && b_ok;
        ev.v0 = accept && (end_f || req_end || a_ok || b_ok);
        ev.r1 = byte_b;
        if (end_f) begin
            ev.r0 = end_res;
        end else if (req_end) begin
            ev.r0 = req_res;
        end else if (a_ok) begin
            ev.r0 = byte_a;
        end else begin
            ev.r0 = byte_b;
        end
        ev.r0.last = !(a_ok && b_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_METHOD;
            len_reg   <= 11'd0;
            hc_reg    <= '0;
            held_reg  <= 1'b0;
            drop_reg  <= 1'b0;
            ep_reg    <= 2'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            hc_reg    <= hc_next;
            held_reg  <= held_next;
            drop_reg  <= drop_next;
            ep_reg    <= ep_next;
        end
    end

    assign in_value    = (phase_reg == PH_VALUE);
    assign req_out     = ev.v0 && (ev.r0.kind == KIND_REQ_END);
    assign state_clear = (phase_reg == PH_METHOD) && (hc_reg == '0);
    assign pair_ok     = (ev.r0.kind == KIND_BYTE) && (ev.r0.field == FIELD_VALUE) &&
                         !ev.r0.last && ev.v0;

    `HRFT_ASSERT_NOW(a_held_in_value, aclk, aresetn, held_reg, in_value, "held CR outside value")
    `HRFT_ASSERT_NOW(a_pair_order, aclk, aresetn, ev.v1, pair_ok, "bad result pair")
    `HRFT_ASSERT_NEXT(a_req_end_clears, aclk, aresetn, req_out, state_clear, "request end left state")

endmodule

/* rtl/hrft_out_queue.sv */
// ----------------------------------------------------------------------------
// HTTP request field tokenizer result queue
// Shift-style queue taking up to two results per cycle and giving one while m_ready is high.
// ----------------------------------------------------------------------------
module hrft_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hrft_pkg::hrft_emit_t   push,
    output logic                   room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hrft_pkg::hrft_result_t m_data
);
    import hrft_pkg::*;
    `include "http_request_field_tokenizer_defines.svh"

    localparam int DEPTH = HRFT_QUEUE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrft_result_t     entry_reg [DEPTH];
    hrft_result_t     entry_next [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base;
    logic             pop;
    logic             drain, first_push;
    logic [CNT_W-1:0] count_dec;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[0];
    // An accepted byte may bring two results, so keep two places free.
    assign room    = (count_reg <= CNT_W'(DEPTH - 2));
    assign base    = count_reg - CNT_W'(pop);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
            if (pop && (i < DEPTH - 1)) begin
                entry_next[i] = entry_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
            if (push.v0 && (base == CNT_W'(i))) begin
                entry_next[i] = push.r0;
            end
            if (push.v1 && (base + CNT_W'(1) == CNT_W'(i))) begin
                entry_next[i] = push.r1;
            end
        end
        count_next = base + CNT_W'(push.v0) + CNT_W'(push.v1);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign drain      = pop && !push.v0;
    assign first_push = (count_reg == '0) && push.v0;
    assign count_dec  = count_reg - CNT_W'(1);

    `HRFT_ASSERT_NOW(a_push_order, aclk, aresetn, push.v1, push.v0, "second result without first")
    `HRFT_ASSERT_NOW(a_pop_count, aclk, aresetn, drain, count_next == count_dec, "pop did not drain")
    `HRFT_ASSERT_NEXT(a_push_shows, aclk, aresetn, first_push, m_valid, "pushed result not shown")

endmodule

/* rtl/http_request_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// HTTP request field tokenizer
// Tags request bytes as method, path, protocol, header key or value.
// ----------------------------------------------------------------------------
//  Channel   Ports                               Handshake
//  input     s_valid, s_ready, s_data            valid/ready, one byte a transfer
//  result    m_valid, m_ready, m_data            valid/ready, one result a transfer
//  config    psel, penable, pwrite, paddr, ...   APB-style, no wait states
//
//  One byte is accepted per cycle while s_ready is high; its results are registered in the queue before they leave.
//  Results wait in a four-entry queue; s_ready drops while more than two are queued,
//  since one byte can produce two results.
//  Reset clears the parse state and loads the limits with their maximum values.
//  A stall on the result side fills the queue and then holds the input side.
module http_request_field_tokenizer #(
    parameter int PATH_MAX_BYTES   = hrft_pkg::HRFT_PATH_MAX_BYTES,
    parameter int HEADER_INDEX_MAX = hrft_pkg::HRFT_HEADER_INDEX_MAX
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hrft_pkg::hrft_in_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hrft_pkg::hrft_result_t m_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import hrft_pkg::*;

    logic [2:0]   method_limit_reg;
    logic [10:0]  path_limit_reg;
    logic [3:0]   protocol_limit_reg;
    logic [7:0]   key_limit_reg;
    logic [8:0]   value_limit_reg;
    hrft_limits_t limits;
    hrft_reg_t    reg_sel;
    logic         cfg_wr;
    logic         accept;
    hrft_emit_t   ev;

    assign pready  = 1'b1;
    assign reg_sel = hrft_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign accept  = s_valid && s_ready;

    assign limits = '{method_limit: method_limit_reg, path_limit: path_limit_reg,
                      protocol_limit: protocol_limit_reg, key_limit: key_limit_reg,
                      value_limit: value_limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_limit_reg   <= METHOD_LIMIT_RST;
            path_limit_reg     <= PATH_LIMIT_RST;
            protocol_limit_reg <= PROTOCOL_LIMIT_RST;
            key_limit_reg      <= KEY_LIMIT_RST;
            value_limit_reg    <= VALUE_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_METHOD_LIMIT:   method_limit_reg   <= pwdata[2:0];
                REG_PATH_LIMIT:     path_limit_reg     <= pwdata[10:0];
                REG_PROTOCOL_LIMIT: protocol_limit_reg <= pwdata[3:0];
                REG_KEY_LIMIT:      key_limit_reg      <= pwdata[7:0];
                REG_VALUE_LIMIT:    value_limit_reg    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_METHOD_LIMIT:   prdata = {29'd0, method_limit_reg};
            REG_PATH_LIMIT:     prdata = {21'd0, path_limit_reg};
            REG_PROTOCOL_LIMIT: prdata = {28'd0, protocol_limit_reg};
            REG_KEY_LIMIT:      prdata = {24'd0, key_limit_reg};
            REG_VALUE_LIMIT:    prdata = {23'd0, value_limit_reg};
            default:            prdata = 32'd0;
        endcase
    end

    hrft_parser #(
        .PATH_MAX_BYTES  (PATH_MAX_BYTES),
        .HEADER_INDEX_MAX(HEADER_INDEX_MAX)
    ) u_parser (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .in_item(s_data),
        .limits (limits),
        .ev     (ev)
    );

    hrft_out_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (ev),
        .room   (s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

/* sim/tb_http_request_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// HTTP request field tokenizer testbench
// Feeds request byte streams through the input channel while both sides stall
// at random in most phases, rewrites the field limits between phases, and compares every
// result transfer with a scoreboard that tokenizes the same bytes itself.
// ----------------------------------------------------------------------------
module tb_http_request_field_tokenizer;
    import hrft_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX = 10;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_SKIP_PATH,
        PH_PATH,
        PH_SKIP_PROTO,
        PH_PROTO,
        PH_GAP,
        PH_KEY,
        PH_VALUE_SKIP,
        PH_VALUE
    } parse_phase_t;

    class token_scoreboard;
        hrft_limits_t limits;
        parse_phase_t phase;
        int           field_len;
        int           header_idx;
        bit           cr_held;
        bit           dropped;
        int           crlf_progress;
        hrft_result_t expected_tokens[$];
        hrft_result_t step_tokens[$];
        int           mismatches;

        function new();
            limits = '{METHOD_LIMIT_RST, PATH_LIMIT_RST, PROTOCOL_LIMIT_RST,
                       KEY_LIMIT_RST, VALUE_LIMIT_RST};
            mismatches = 0;
            clear_parse();
        endfunction

        static function bit is_blank(logic [7:0] b);
            return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function int outstanding();
            return expected_tokens.size();
        endfunction

        function void set_limit(hrft_reg_t idx, logic [31:0] value);
            case (idx)
                REG_METHOD_LIMIT:   limits.method_limit = value[2:0];
                REG_PATH_LIMIT:     limits.path_limit = value[10:0];
                REG_PROTOCOL_LIMIT: limits.protocol_limit = value[3:0];
                REG_KEY_LIMIT:      limits.key_limit = value[7:0];
                default:            limits.value_limit = value[8:0];
            endcase
        endfunction

        function void clear_parse();
            phase = PH_METHOD;
            field_len = 0;
            header_idx = 0;
            cr_held = 0;
            dropped = 0;
            crlf_progress = 0;
        endfunction

        function int limit_for(logic [2:0] fld);
            int lim;
            case (fld)
                FIELD_METHOD: lim = limits.method_limit;
                FIELD_PATH: begin
                    lim = limits.path_limit;
                    if (lim > HRFT_PATH_MAX_BYTES - 1) lim = HRFT_PATH_MAX_BYTES - 1;
                end
                FIELD_PROTOCOL: lim = limits.protocol_limit;
                FIELD_KEY:      lim = limits.key_limit;
                default:        lim = limits.value_limit;
            endcase
            return lim;
        endfunction

        function void emit(logic [1:0] kind, logic [2:0] fld, int off, bit trunc,
                           logic [7:0] b);
            hrft_result_t r;
            if (step_tokens.size() >= 2) return;
            r.kind = kind;
            r.field = fld;
            r.header_number = 8'(header_idx);
            r.offset = 11'(off);
            r.truncated = trunc;
            r.out_byte = b;
            r.last = 1'b0;
            step_tokens.push_back(r);
        endfunction

        function void keep_byte(logic [2:0] fld, logic [7:0] b);
            if (field_len < limit_for(fld)) begin
                emit(KIND_BYTE, fld, field_len, 1'b0, b);
                field_len++;
            end else begin
                dropped = 1'b1;
            end
        endfunction

        function void close_field(logic [2:0] fld);
            emit(KIND_FIELD_END, fld, field_len, dropped, 8'd0);
            field_len = 0;
            dropped = 1'b0;
        endfunction

        function void take_word_byte(logic [2:0] fld, logic [7:0] b, parse_phase_t next);
            if (is_blank(b)) begin
                close_field(fld);
                phase = next;
                crlf_progress = (b == CH_CR) ? 1 : 0;
            end else begin
                keep_byte(fld, b);
            end
        endfunction

        // Between lines the parser counts its way through CR LF CR LF.
        function void take_gap_byte(logic [7:0] b);
            if (b == CH_CR) begin
                crlf_progress = (crlf_progress == 2) ? 3 : 1;
            end else if (b == CH_LF) begin
                if (crlf_progress == 1) begin
                    crlf_progress = 2;
                end else if (crlf_progress == 3) begin
                    emit(KIND_REQ_END, FIELD_METHOD, 0, 1'b0, 8'd0);
                    clear_parse();
                end else begin
                    crlf_progress = 0;
                end
            end else if (is_blank(b)) begin
                crlf_progress = 0;
            end else begin
                crlf_progress = 0;
                phase = PH_KEY;
                keep_byte(FIELD_KEY, b);
            end
        endfunction

        // A CR inside a value is held until the next byte shows whether it ends the line.
        function void take_value_byte(logic [7:0] b);
            if (cr_held) begin
                cr_held = 1'b0;
                if (b == CH_LF) begin
                    close_field(FIELD_VALUE);
                    if (header_idx < HRFT_HEADER_INDEX_MAX) header_idx++;
                    phase = PH_GAP;
                    crlf_progress = 2;
                    return;
                end
                keep_byte(FIELD_VALUE, CH_CR);
            end
            if (b == CH_CR) cr_held = 1'b1;
            else keep_byte(FIELD_VALUE, b);
        endfunction

        function void tokenize(logic [7:0] b);
            case (phase)
                PH_SKIP_PATH: begin
                    if (!is_blank(b)) begin
                        phase = PH_PATH;
                        keep_byte(FIELD_PATH, b);
                    end
                end
                PH_PATH:       take_word_byte(FIELD_PATH, b, PH_SKIP_PROTO);
                PH_SKIP_PROTO: begin
                    if (!is_blank(b)) begin
                        phase = PH_PROTO;
                        keep_byte(FIELD_PROTOCOL, b);
                    end
                end
                PH_PROTO:      take_word_byte(FIELD_PROTOCOL, b, PH_GAP);
                PH_GAP:        take_gap_byte(b);
                PH_KEY: begin
                    if (b == CH_COLON) begin
                        close_field(FIELD_KEY);
                        phase = PH_VALUE_SKIP;
                    end else begin
                        keep_byte(FIELD_KEY, b);
                    end
                end
                PH_VALUE_SKIP: begin
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                        phase = PH_VALUE;
                    end else if (!is_blank(b)) begin
                        phase = PH_VALUE;
                        keep_byte(FIELD_VALUE, b);
                    end
                end
                PH_VALUE:      take_value_byte(b);
                default: begin
                    phase = PH_METHOD;
                    take_word_byte(FIELD_METHOD, b, PH_SKIP_PATH);
                end
            endcase
        endfunction

        function void note_byte(hrft_in_t item);
            step_tokens.delete();
            if (item.restart) clear_parse();
            tokenize(item.data_byte);
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
        endfunction

        function string describe(hrft_result_t r);
            return $sformatf("kind=%0d field=%0d header=%0d offset=%0d truncated=%0b byte=%02h last=%0b",
                             r.kind, r.field, r.header_number, r.offset, r.truncated,
                             r.out_byte, r.last);
        endfunction

        function void check_token(hrft_result_t got);
            hrft_result_t want;
            bit bad;
            if (expected_tokens.size() == 0) begin
                if (mismatches < REPORT_MAX) $display("unexpected result: %s", describe(got));
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            bad = (got.kind !== want.kind) || (got.field !== want.field) ||
                  (got.header_number !== want.header_number) ||
                  (got.offset !== want.offset) || (got.truncated !== want.truncated) ||
                  (got.out_byte !== want.out_byte) || (got.last !== want.last);
            if (bad) begin
                if (mismatches < REPORT_MAX) begin
                    $display("mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
                mismatches++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    hrft_in_t     s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    hrft_result_t m_data;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    token_scoreboard board = new();
    hrft_in_t        byte_plan[$];
    bit              pending_restart = 1'b0;
    bit              dirty = 1'b0;
    bit              steady_run = 1'b0;
    int              sink_hold = 0;
    int              cycle_count = 0;

    http_request_field_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic bit roll_idle();
        return !steady_run && ($urandom_range(99) < 15);
    endfunction

    function automatic logic [7:0] solid_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (token_scoreboard::is_blank(b));
        return b;
    endfunction

    function automatic logic [7:0] any_but(logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == avoid);
        return b;
    endfunction

    function automatic int pick_len(int lim, int span, int least);
        int top;
        top = lim + 2;
        if (top > span) top = span;
        if (top < least) top = least;
        return $urandom_range(top, least);
    endfunction

    function automatic void put(logic [7:0] b);
        byte_plan.push_back('{data_byte: b, restart: pending_restart});
        pending_restart = 1'b0;
    endfunction

    function automatic void plan_blanks(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(5);
            put(pick < 5 ? 8'(9 + pick) : CH_SPACE);
        end
    endfunction

    // One request with random field contents; a broken one is cut off part way.
    function automatic void plan_request(int n_headers, int span, bit broken);
        int start;
        start = byte_plan.size();
        pending_restart = dirty || ($urandom_range(3) == 0);
        dirty = 1'b0;
        repeat (pick_len(board.limits.method_limit, span, 0)) put(solid_byte());
        plan_blanks($urandom_range(3, 1));
        repeat (pick_len(board.limits.path_limit, span, 1)) put(solid_byte());
        plan_blanks($urandom_range(3, 1));
        repeat (pick_len(board.limits.protocol_limit, span, 1)) put(solid_byte());
        if ($urandom_range(3) == 0) put(CH_SPACE);
        put(CH_CR);
        put(CH_LF);
        repeat (n_headers) begin
            put(any_but(CH_COLON) | 8'h00);
            if (token_scoreboard::is_blank(byte_plan[byte_plan.size() - 1].data_byte) ||
                byte_plan[byte_plan.size() - 1].data_byte == CH_COLON) begin
                void'(byte_plan.pop_back());
                put(8'h6B);
            end
            repeat (pick_len(board.limits.key_limit, span, 1) - 1) put(any_but(CH_COLON));
            put(CH_COLON);
            repeat ($urandom_range(2)) put($urandom_range(1) ? CH_SPACE : 8'd9);
            repeat (pick_len(board.limits.value_limit, span, 0)) begin
                if ($urandom_range(7) == 0) begin
                    put(CH_CR);
                    put(any_but(CH_LF));
                end else begin
                    put(any_but(CH_CR));
                end
            end
            put(CH_CR);
            put(CH_LF);
        end
        put(CH_CR);
        put(CH_LF);
        if (broken) begin
            start = start + $urandom_range(byte_plan.size() - start - 1, 1);
            while (byte_plan.size() > start) void'(byte_plan.pop_back());
            dirty = 1'b1;
        end
    endfunction

    function automatic void plan_noise(int n);
        repeat (n) begin
            pending_restart = ($urandom_range(15) == 0);
            put(8'($urandom_range(255)));
        end
        dirty = 1'b1;
    endfunction

    task automatic send_byte(hrft_in_t item);
        while (roll_idle()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_byte(item);
    endtask

    task automatic send_plan();
        foreach (byte_plan[i]) send_byte(byte_plan[i]);
        byte_plan.delete();
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.outstanding() != 0);
    endtask

    // Bytes that produce no result may still be inside the block when the queue runs dry.
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(hrft_reg_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        board.set_limit(idx, value);
    endtask

    task automatic apply_limits(hrft_limits_t lim);
        apb_write(REG_METHOD_LIMIT, 32'(lim.method_limit));
        apb_write(REG_PATH_LIMIT, 32'(lim.path_limit));
        apb_write(REG_PROTOCOL_LIMIT, 32'(lim.protocol_limit));
        apb_write(REG_KEY_LIMIT, 32'(lim.key_limit));
        apb_write(REG_VALUE_LIMIT, 32'(lim.value_limit));
    endtask

    task automatic apply_random_limits();
        hrft_limits_t lim;
        lim.method_limit = 3'($urandom_range(7, 1));
        lim.path_limit = 11'($urandom_range(40, 1));
        lim.protocol_limit = 4'($urandom_range(15, 1));
        lim.key_limit = 8'($urandom_range(16, 1));
        lim.value_limit = 9'($urandom_range(24, 1));
        apply_limits(lim);
    endtask

    task automatic run_traffic(int n_items, bit pause_midway);
        int sent;
        int pick;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            pick = $urandom_range(9);
            if (pick < 7) plan_request($urandom_range(4), 24, 1'b0);
            else if (pick < 9) plan_request($urandom_range(3), 24, 1'b1);
            else plan_noise($urandom_range(12, 1));
            sent += byte_plan.size();
            send_plan();
            if (pause_midway && !paused && sent >= n_items / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) board.check_token(m_data);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else begin
                m_ready <= !roll_idle();
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0] opening [26];
        opening = '{CH_SPACE, "/", CH_SPACE, "H", CH_CR, CH_LF, CH_CR, CH_LF,
                    8'hFF, CH_SPACE, "/", CH_SPACE, "P", CH_CR, CH_LF,
                    "k", CH_SPACE, CH_COLON, CH_CR, CH_LF,
                    "v", CH_COLON, 8'h00, CH_CR, "b", CH_CR};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty method, a request with no headers, a key with a blank in it, an empty
        // value, a CR inside a value, then a restart that drops a held CR.
        pending_restart = 1'b1;
        foreach (opening[i]) put(opening[i]);
        pending_restart = 1'b1;
        put("G");
        dirty = 1'b1;
        send_plan();
        settle();

        apply_limits('{3'd1, 11'd1, 4'd1, 8'd1, 9'd1});
        run_traffic(100, 1'b0);
        settle();

        apply_limits('0);
        run_traffic(50, 1'b0);
        settle();

        apply_limits('{METHOD_LIMIT_RST, 11'd24, PROTOCOL_LIMIT_RST,
                       KEY_LIMIT_RST, VALUE_LIMIT_RST});
        // The result side holds off while a path longer than its limit streams in.
        sink_hold = 400;
        pending_restart = 1'b1;
        dirty = 1'b0;
        put("G");
        put(CH_SPACE);
        repeat (40) put(solid_byte());
        put(CH_SPACE);
        put("H");
        put(CH_CR);
        put(CH_LF);
        put(CH_CR);
        put(CH_LF);
        send_plan();
        // A run of minimal headers back to back.
        plan_request(6, 1, 1'b0);
        send_plan();
        run_traffic(120, 1'b1);
        settle();

        apply_random_limits();
        steady_run = 1'b1;
        run_traffic(80, 1'b0);
        steady_run = 1'b0;
        settle();

        repeat (3) begin
            apply_random_limits();
            run_traffic(50, 1'b0);
            settle();
        end

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/hrft_pkg.sv
rtl/hrft_parser.sv
rtl/hrft_out_queue.sv
rtl/http_request_field_tokenizer.sv
sim/tb_http_request_field_tokenizer.sv
